// File: src/dhmap_pkg.sv
// shared types, codes and level tables for the double hashing map
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dhmap_pkg;

  localparam int HASH_BITS    = 32;
  localparam int FUNC_BITS    = 2;
  localparam int LEVEL_BITS   = 5;
  localparam int CNT_OUT_BITS = 10;
  localparam int LEVELS       = 30;

  typedef enum logic [1:0] {
    MARK_FREE = 2'd0,
    MARK_LIVE = 2'd1,
    MARK_TOMB = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_UNHASH  = 2'd2,
    ST_NOSLOT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PR_HIT   = 2'd0,
    PR_AVAIL = 2'd1,
    PR_NONE  = 2'd2
  } probe_res_t;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    C_NOP, C_LOAD, C_CLR, C_PSTART, C_MSTART, C_MODW, C_RD, C_EV, C_ACT,
    C_GINIT, C_GRD, C_GEV, C_GPUT, C_GCLR, C_GFIN
  } cmd_t;

  typedef struct packed {
    logic clr_all_last;
    logic clr_old_last;
    logic mod_done;
    logic pe_end;
    logic g_live;
    logic g_last;
    logic grow_need;
    logic skip;
    logic out_free;
  } dp_stat_t;

  function automatic logic [31:0] level_size(input logic [LEVEL_BITS-1:0] lvl);
    logic [31:0] s;
    unique case (lvl)
      5'd0:    s = 32'd5;
      5'd1:    s = 32'd7;
      5'd2:    s = 32'd13;
      5'd3:    s = 32'd19;
      5'd4:    s = 32'd43;
      5'd5:    s = 32'd73;
      5'd6:    s = 32'd151;
      5'd7:    s = 32'd283;
      5'd8:    s = 32'd571;
      5'd9:    s = 32'd1153;
      5'd10:   s = 32'd2269;
      5'd11:   s = 32'd4519;
      5'd12:   s = 32'd9013;
      5'd13:   s = 32'd18043;
      5'd14:   s = 32'd36109;
      5'd15:   s = 32'd72091;
      5'd16:   s = 32'd144409;
      5'd17:   s = 32'd288361;
      5'd18:   s = 32'd576883;
      5'd19:   s = 32'd1153459;
      5'd20:   s = 32'd2307163;
      5'd21:   s = 32'd4613893;
      5'd22:   s = 32'd9227641;
      5'd23:   s = 32'd18455029;
      5'd24:   s = 32'd36911011;
      5'd25:   s = 32'd73819861;
      5'd26:   s = 32'd147639589;
      5'd27:   s = 32'd295279081;
      5'd28:   s = 32'd590559793;
      5'd29:   s = 32'd1181116273;
      default: s = 32'd0;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] level_limit(input logic [LEVEL_BITS-1:0] lvl);
    return 32'd2 << lvl;
  endfunction

  // highest level, not above top, whose size still fits in one bank
  function automatic int eff_top(input int top, input int depth);
    int lim;
    int t;
    lim = (top > LEVELS - 1) ? LEVELS - 1 : top;
    t = 0;
    for (int k = 0; k < LEVELS - 1; k++) begin
      if (t < lim && int'(level_size(LEVEL_BITS'(t + 1))) <= depth) begin
        t = t + 1;
      end
    end
    return t;
  endfunction

endpackage

// File: src/dhmap_rem.sv
// bit-serial remainder unit: hash mod divisor, one quotient bit per cycle
// depends on dhmap_pkg
`timescale 1ns / 1ps

module dhmap_rem #(
  parameter int DW = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dhmap_pkg::HASH_BITS-1:0] dividend,
  input  logic [DW-1:0]                 divisor,
  output logic [DW-1:0]                 rem,
  output logic                          done
);
  import dhmap_pkg::*;

  localparam int CNTW = $clog2(HASH_BITS);

  logic [HASH_BITS-1:0] dvd_r;
  logic [DW-1:0]        div_r;
  logic [DW-1:0]        rem_r;
  logic [CNTW-1:0]      cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DW:0]          trial;
  logic [DW:0]          diff;
  logic                 fits;

  assign trial = {rem_r, dvd_r[HASH_BITS-1]};
  assign fits  = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNTW'(1);
      if (cnt_r == CNTW'(HASH_BITS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= fits ? DW'(diff) : DW'(trial);
    end
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

// File: src/dhmap_dp.sv
// datapath: slot memories, probe walk, growth moves and result register
// depends on dhmap_pkg and dhmap_rem
`timescale 1ns / 1ps

module dhmap_dp #(
  parameter int TOP_LEVEL  = 6,
  parameter int BANK_DEPTH = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dhmap_pkg::cmd_t                    cmd,
  output dhmap_pkg::dp_stat_t                stat,
  input  logic [dhmap_pkg::FUNC_BITS-1:0]    in_func,
  input  logic [31:0]                        in_key,
  input  logic [dhmap_pkg::HASH_BITS-1:0]    in_hash,
  input  logic [31:0]                        in_value,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [31:0]                        out_value,
  output logic [dhmap_pkg::CNT_OUT_BITS-1:0] out_count
);
  import dhmap_pkg::*;

  localparam int IW      = $clog2(BANK_DEPTH);
  localparam int SW      = $clog2(BANK_DEPTH + 1);
  localparam int DEPTH2  = 2 * BANK_DEPTH;
  localparam int AW      = $clog2(DEPTH2);
  localparam int CW      = (SW > CNT_OUT_BITS) ? SW : CNT_OUT_BITS;
  localparam int DWID    = HASH_BITS + KEY_BITS + VALUE_BITS;
  localparam int EFF_TOP = eff_top(TOP_LEVEL, BANK_DEPTH);
  localparam logic [AW-1:0] BASE1 = AW'(BANK_DEPTH);

  function automatic logic [AW-1:0] slot_addr(input logic b, input logic [IW-1:0] idx);
    return (b ? BASE1 : '0) + AW'(idx);
  endfunction

  // item registers
  op_t                   op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [HASH_BITS-1:0]  hash_r;
  logic [VALUE_BITS-1:0] val_r;
  // table state
  logic [LEVEL_BITS-1:0] level_r;
  logic                  bank_r;
  logic [CW-1:0]         count_r;
  // probe context
  logic [KEY_BITS-1:0]   pk_r;
  logic [HASH_BITS-1:0]  ph_r;
  logic [VALUE_BITS-1:0] mv_r;
  logic [SW-1:0]         psize_r;
  logic                  pbank_r;
  logic [IW-1:0]         i_r;
  logic [IW-1:0]         start_r;
  logic [SW-1:0]         step_r;
  logic                  have_r;
  logic [IW-1:0]         avail_r;
  logic [IW-1:0]         where_r;
  probe_res_t            res_r;
  logic [VALUE_BITS-1:0] hv_r;
  logic [IW-1:0]         g_r;
  logic [AW-1:0]         clr_r;
  // result register
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [31:0]           out_value_r;
  logic [CW-1:0]         out_count_r;

  // slot memories
  mark_t                 mark_mem [DEPTH2];
  logic [DWID-1:0]       data_mem [DEPTH2];
  mark_t                 mark_q;
  logic [DWID-1:0]       data_q;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic                  mark_we;
  logic                  data_we;
  mark_t                 mark_wd;
  logic [DWID-1:0]       data_wd;

  logic [SW-1:0]         cur_size;
  logic [SW-1:0]         next_size;
  logic [SW-1:0]         rem_a;
  logic [SW-1:0]         rem_b;
  logic                  done_a;
  logic                  done_b;
  logic                  mstart;

  logic [HASH_BITS-1:0]  d_hash;
  logic [KEY_BITS-1:0]   d_key;
  logic [VALUE_BITS-1:0] d_val;
  logic                  live;
  logic                  match;
  logic [SW:0]           sum;
  logic [SW:0]           wrapped;
  logic [IW-1:0]         nxt_i;
  logic                  pe_end;
  probe_res_t            pe_res;
  logic [IW-1:0]         pe_where;

  logic                  skip;
  logic                  out_free;
  logic                  act_go;
  status_t               act_st;
  logic [31:0]           act_fv;
  logic [CW-1:0]         act_cnt;

  assign cur_size  = SW'(level_size(level_r));
  assign next_size = SW'(level_size(level_r + LEVEL_BITS'(1)));
  assign mstart    = (cmd == C_MSTART);

  dhmap_rem #(.DW(SW)) u_rem_start (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mstart),
    .dividend (ph_r),
    .divisor  (psize_r),
    .rem      (rem_a),
    .done     (done_a)
  );

  dhmap_rem #(.DW(SW)) u_rem_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mstart),
    .dividend (ph_r),
    .divisor  (psize_r - SW'(2)),
    .rem      (rem_b),
    .done     (done_b)
  );

  // probe evaluation on the registered slot read
  assign d_val   = data_q[VALUE_BITS-1:0];
  assign d_key   = data_q[VALUE_BITS +: KEY_BITS];
  assign d_hash  = data_q[VALUE_BITS + KEY_BITS +: HASH_BITS];
  assign live    = (mark_q == MARK_LIVE);
  assign match   = live && (d_hash == ph_r) && (d_key == pk_r);
  assign sum     = {1'b0, SW'(i_r)} + {1'b0, step_r};
  assign wrapped = (sum >= {1'b0, psize_r}) ? sum - {1'b0, psize_r} : sum;
  assign nxt_i   = IW'(wrapped);
  assign pe_end  = match || (mark_q == MARK_FREE) || (nxt_i == start_r);
  assign pe_res  = match ? PR_HIT : ((have_r || !live) ? PR_AVAIL : PR_NONE);
  assign pe_where = (match || !have_r) ? i_r : avail_r;

  assign skip     = (op_r == OP_NONE) || (hash_r == '0);
  assign out_free = !out_valid_r || out_ready;
  assign act_go   = (cmd == C_ACT) && out_free;

  // outcome of the item once the probe is settled
  always_comb begin
    act_st  = ST_OK;
    act_fv  = '0;
    act_cnt = count_r;
    if (op_r == OP_NONE) begin
      act_st = ST_OK;
    end else if (hash_r == '0) begin
      act_st = ST_UNHASH;
    end else begin
      unique case (op_r)
        OP_GET: begin
          if (res_r == PR_HIT) begin
            act_fv = 32'(hv_r);
          end else begin
            act_st = ST_ABSENT;
          end
        end
        OP_INSERT: begin
          if (res_r == PR_NONE) begin
            act_st = ST_NOSLOT;
          end else begin
            act_fv = 32'(val_r);
            if (res_r == PR_AVAIL) begin
              act_cnt = count_r + CW'(1);
            end
          end
        end
        OP_DELETE: begin
          if (res_r == PR_HIT) begin
            if (count_r != '0) begin
              act_cnt = count_r - CW'(1);
            end
          end else begin
            act_st = ST_ABSENT;
          end
        end
        default: act_st = ST_OK;
      endcase
    end
  end

  // memory write port
  always_comb begin
    mark_we = 1'b0;
    data_we = 1'b0;
    mark_wd = MARK_FREE;
    data_wd = {ph_r, pk_r, val_r};
    wr_addr = slot_addr(pbank_r, where_r);
    unique case (cmd)
      C_CLR: begin
        mark_we = 1'b1;
        wr_addr = clr_r;
      end
      C_GCLR: begin
        mark_we = 1'b1;
        wr_addr = slot_addr(bank_r, IW'(clr_r));
      end
      C_GPUT: begin
        data_wd = {ph_r, pk_r, mv_r};
        mark_wd = MARK_LIVE;
        if (res_r != PR_NONE) begin
          mark_we = 1'b1;
          data_we = 1'b1;
        end
      end
      C_ACT: begin
        if (out_free && !skip) begin
          if (op_r == OP_INSERT && res_r == PR_AVAIL) begin
            mark_we = 1'b1;
            mark_wd = MARK_LIVE;
            data_we = 1'b1;
          end else if (op_r == OP_INSERT && res_r == PR_HIT) begin
            data_we = 1'b1;
          end else if (op_r == OP_DELETE && res_r == PR_HIT) begin
            mark_we = 1'b1;
            mark_wd = MARK_TOMB;
          end
        end
      end
      default: mark_we = 1'b0;
    endcase
  end

  assign rd_addr = (cmd == C_GRD) ? slot_addr(bank_r, g_r) : slot_addr(pbank_r, i_r);

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[wr_addr] <= mark_wd;
    end
    mark_q <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[wr_addr] <= data_wd;
    end
    data_q <= data_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      bank_r      <= 1'b0;
      count_r     <= '0;
      clr_r       <= '0;
      g_r         <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (act_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd)
        C_CLR, C_GCLR: clr_r <= clr_r + AW'(1);
        C_MODW: begin
          if (done_a && done_b) begin
            have_r <= 1'b0;
          end
        end
        C_EV: begin
          if (!live && !have_r) begin
            have_r <= 1'b1;
          end
        end
        C_ACT: begin
          if (out_free) begin
            count_r <= act_cnt;
          end
        end
        C_GINIT: begin
          g_r     <= '0;
          count_r <= '0;
          clr_r   <= '0;
        end
        C_GEV: begin
          if (!live) begin
            g_r <= g_r + IW'(1);
          end
        end
        C_GPUT: begin
          g_r <= g_r + IW'(1);
          if (res_r != PR_NONE) begin
            count_r <= count_r + CW'(1);
          end
        end
        C_GFIN: begin
          bank_r  <= ~bank_r;
          level_r <= level_r + LEVEL_BITS'(1);
        end
        default: level_r <= level_r;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (act_go) begin
      out_status_r <= act_st;
      out_value_r  <= act_fv;
      out_count_r  <= act_cnt;
    end
    unique case (cmd)
      C_LOAD: begin
        op_r   <= op_t'(in_func);
        key_r  <= KEY_BITS'(in_key);
        hash_r <= in_hash;
        val_r  <= VALUE_BITS'(in_value);
      end
      C_PSTART: begin
        pk_r    <= key_r;
        ph_r    <= hash_r;
        psize_r <= cur_size;
        pbank_r <= bank_r;
      end
      C_MODW: begin
        i_r     <= IW'(rem_a);
        start_r <= IW'(rem_a);
        step_r  <= rem_b + SW'(1);
      end
      C_EV: begin
        if (match) begin
          hv_r <= d_val;
        end
        if (!live && !have_r) begin
          avail_r <= i_r;
        end
        i_r <= nxt_i;
        if (pe_end) begin
          res_r   <= pe_res;
          where_r <= pe_where;
        end
      end
      C_GEV: begin
        if (live) begin
          pk_r    <= d_key;
          ph_r    <= d_hash;
          mv_r    <= d_val;
          psize_r <= next_size;
          pbank_r <= ~bank_r;
        end
      end
      default: pk_r <= pk_r;
    endcase
  end

  assign stat.clr_all_last = (clr_r == AW'(DEPTH2 - 1));
  assign stat.clr_old_last = (clr_r == AW'(cur_size) - AW'(1));
  assign stat.mod_done     = done_a && done_b;
  assign stat.pe_end       = pe_end;
  assign stat.g_live       = live;
  assign stat.g_last       = (SW'(g_r) == cur_size - SW'(1));
  assign stat.grow_need    = (op_r == OP_INSERT) && (hash_r != '0)
                             && (32'(count_r) >= level_limit(level_r))
                             && (level_r < LEVEL_BITS'(EFF_TOP));
  assign stat.skip         = skip;
  assign stat.out_free     = out_free;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_count  = CNT_OUT_BITS'(out_count_r);

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(BANK_DEPTH))
    else $error("live entry count above bank depth");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LEVEL_BITS'(EFF_TOP))
    else $error("size level beyond top level");

  a_probe_index: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == C_EV) |-> (SW'(i_r) < psize_r))
    else $error("probe index outside table");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    act_go |=> out_valid_r)
    else $error("finished item not presented");
`endif

endmodule

// File: src/dhmap_ctrl.sv
// controller: sequences clear, probe, growth and result steps of each item
// depends on dhmap_pkg
`timescale 1ns / 1ps

module dhmap_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dhmap_pkg::dp_stat_t stat,
  output dhmap_pkg::cmd_t     cmd
);
  import dhmap_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_MST, S_MOD, S_PRD, S_PEV, S_ACT,
    S_GINIT, S_GRD, S_GEV, S_GPUT, S_GCLR, S_GFIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   grow_r;
  logic   grow_nxt;

  always_comb begin
    state_nxt = state_r;
    grow_nxt  = grow_r;
    cmd       = C_NOP;
    unique case (state_r)
      S_CLR: begin
        cmd = C_CLR;
        if (stat.clr_all_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd       = C_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd      = C_PSTART;
        grow_nxt = 1'b0;
        priority if (stat.skip) state_nxt = S_ACT;
        else if (stat.grow_need) state_nxt = S_GINIT;
        else state_nxt = S_MST;
      end
      S_MST: begin
        cmd       = C_MSTART;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd = C_MODW;
        if (stat.mod_done) state_nxt = S_PRD;
      end
      S_PRD: begin
        cmd       = C_RD;
        state_nxt = S_PEV;
      end
      S_PEV: begin
        cmd = C_EV;
        if (stat.pe_end) state_nxt = grow_r ? S_GPUT : S_ACT;
        else state_nxt = S_PRD;
      end
      S_ACT: begin
        cmd = C_ACT;
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_GINIT: begin
        cmd       = C_GINIT;
        grow_nxt  = 1'b1;
        state_nxt = S_GRD;
      end
      S_GRD: begin
        cmd       = C_GRD;
        state_nxt = S_GEV;
      end
      S_GEV: begin
        cmd = C_GEV;
        priority if (stat.g_live) state_nxt = S_MST;
        else if (stat.g_last) state_nxt = S_GCLR;
        else state_nxt = S_GRD;
      end
      S_GPUT: begin
        cmd       = C_GPUT;
        state_nxt = stat.g_last ? S_GCLR : S_GRD;
      end
      S_GCLR: begin
        cmd = C_GCLR;
        if (stat.clr_old_last) state_nxt = S_GFIN;
      end
      S_GFIN: begin
        cmd       = C_GFIN;
        state_nxt = S_DISP;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      grow_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      grow_r  <= grow_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// File: src/double_hash_open_address_map.sv
// top level of the double hashing key-value map
// depends on dhmap_pkg, dhmap_ctrl and dhmap_dp
`timescale 1ns / 1ps

// Usage:
// in channel carries one request per transaction: in_tuser holds the operation
// (get, insert, delete), in_tdata the key, its precomputed hash and the value.
// out channel returns one result per request: status in out_tuser, the value
// read or stored and the live entry count in out_tdata.
// After reset the block sweeps every slot of both banks to free, with in_tready
// low; then it takes one request at a time.
// Per request: load and dispatch, then a start and a step remainder come from
// two bit-serial units (start, one step per hash bit, done seen), then each
// probed slot is read from memory and compared, then the result is set; the
// next request is taken once the result is registered. Unhashable keys go from
// dispatch straight to the result.
// An insert at the load limit below the top level first grows the table: each
// old slot is read and checked, each live entry takes a further probe in the
// new bank, then the old bank is cleared at one slot per cycle.
// The result sits in an output register; a stalled receiver holds it while
// the next request is accepted and worked on, which waits only to deliver.
module double_hash_open_address_map #(
  parameter int TOP_LEVEL  = 6,
  parameter int BANK_DEPTH = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // key[31:0], key_hash[63:32], value[95:64]
  input  logic [1:0]   in_tuser,   // func[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,  // found_value[31:0], live_count[41:32], zero pad
  output logic [1:0]   out_tuser   // status[1:0]
);
  import dhmap_pkg::*;

  cmd_t                    cmd;
  dp_stat_t                stat;
  logic [31:0]             found_value;
  logic [CNT_OUT_BITS-1:0] live_count;

  dhmap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dhmap_dp #(
    .TOP_LEVEL  (TOP_LEVEL),
    .BANK_DEPTH (BANK_DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (in_tuser),
    .in_key     (in_tdata[31:0]),
    .in_hash    (in_tdata[63:32]),
    .in_value   (in_tdata[95:64]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_value  (found_value),
    .out_count  (live_count)
  );

  assign out_tdata = {6'd0, live_count, found_value};

endmodule
